// File: rtl/ftbc_pkg.sv
// Shared constants, control structs and index helpers of the force/torque calibration block.
package ftbc_pkg;

    localparam int CHANNELS   = 6;
    localparam int NUM_COEFS  = CHANNELS * CHANNELS;
    localparam int COEF_BITS  = 24;
    localparam int COUNT_W    = 10;
    localparam int SHIFT_W    = 5;
    localparam int DIV_W      = COUNT_W + 1;
    localparam int OUT_W      = 32;
    localparam int CMD_W      = 2;
    localparam int CIDX_W     = 6;
    localparam int LANE_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SHIFT  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_COEF    = 2'd0,
        CMD_BIAS    = 2'd1,
        CMD_MEASURE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    // Coefficient write into one row lane
    typedef struct packed {
        logic              en;
        logic [LANE_W-1:0] col;
    } t_coef_wr;

    // Sequencing of the row lanes
    typedef struct packed {
        logic              clr;
        logic              mul;
        logic              acc;
        logic              fin;
        logic [LANE_W-1:0] col;
    } t_row_ctrl;

    // Sequencing of the bias lanes
    typedef struct packed {
        logic acc;
        logic start;
        logic step;
        logic last;
    } t_bias_ctrl;

    // Row of a coefficient slot: slot divided by six
    function automatic logic [LANE_W-1:0] coef_row(input logic [CIDX_W-1:0] idx);
        logic [LANE_W-1:0] row;
        if (idx >= CIDX_W'(30))      row = 3'd5;
        else if (idx >= CIDX_W'(24)) row = 3'd4;
        else if (idx >= CIDX_W'(18)) row = 3'd3;
        else if (idx >= CIDX_W'(12)) row = 3'd2;
        else if (idx >= CIDX_W'(6))  row = 3'd1;
        else                         row = 3'd0;
        return row;
    endfunction

    // Column of a coefficient slot: slot minus six times its row
    function automatic logic [LANE_W-1:0] coef_col(input logic [CIDX_W-1:0] idx);
        logic [CIDX_W-1:0] rem;
        rem = idx - ({3'b000, coef_row(idx)} * CIDX_W'(CHANNELS));
        return rem[LANE_W-1:0];
    endfunction

endpackage

// File: rtl/ftbc_in_if.sv
// Input channel: command, coefficient slot and value, six raw converter codes.
interface ftbc_in_if #(parameter int SAMPLE_BITS = 16);
    import ftbc_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [CMD_W-1:0]            command;
    logic [CIDX_W-1:0]           coef_index;
    logic signed [COEF_BITS-1:0] coef_value;
    logic [SAMPLE_BITS-1:0]      sample_ch0;
    logic [SAMPLE_BITS-1:0]      sample_ch1;
    logic [SAMPLE_BITS-1:0]      sample_ch2;
    logic [SAMPLE_BITS-1:0]      sample_ch3;
    logic [SAMPLE_BITS-1:0]      sample_ch4;
    logic [SAMPLE_BITS-1:0]      sample_ch5;

    modport source (
        output valid, command, coef_index, coef_value,
        output sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, sample_ch5,
        input  ready
    );
    modport sink (
        input  valid, command, coef_index, coef_value,
        input  sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, sample_ch5,
        output ready
    );
endinterface

// File: rtl/ftbc_out_if.sv
// Output channel: six calibrated force/torque values and the bias-valid flag.
interface ftbc_out_if;
    import ftbc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic signed [OUT_W-1:0] torque_x;
    logic signed [OUT_W-1:0] torque_y;
    logic signed [OUT_W-1:0] torque_z;
    logic                    bias_valid;

    modport source (
        output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z, bias_valid,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, force_z, torque_x, torque_y, torque_z, bias_valid,
        output ready
    );
endinterface

// File: rtl/ftbc_bias_lane.sv
// One channel's bias accumulator with a bit-serial restoring divider.
module ftbc_bias_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ftbc_pkg::t_bias_ctrl          i_ctrl,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic [ftbc_pkg::DIV_W-1:0]    i_div,
    output logic [SAMPLE_BITS-1:0]        o_bias
);
    import ftbc_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + COUNT_W;

    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       r_quo;
    logic [DIV_W-1:0]       r_rem;
    logic [SAMPLE_BITS-1:0] r_bias;

    logic [SUM_W-1:0] w_sum_nx;
    logic [DIV_W:0]   w_trial;
    logic             w_qbit;
    logic [DIV_W-1:0] w_rem_nx;
    logic [SUM_W-1:0] w_quo_nx;

    // Add the incoming code to the running sum
    assign w_sum_nx = r_sum + SUM_W'(i_sample);

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign w_trial  = {r_rem, r_quo[SUM_W-1]};
    assign w_qbit   = (w_trial >= {1'b0, i_div});
    assign w_rem_nx = w_qbit ? DIV_W'(w_trial - {1'b0, i_div}) : w_trial[DIV_W-1:0];
    assign w_quo_nx = {r_quo[SUM_W-2:0], w_qbit};

    // Accumulate, or hand the sum over to the divider and clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.start) begin
            r_sum <= '0;
        end else if (i_ctrl.acc) begin
            r_sum <= w_sum_nx;
        end
    end

    // Shift the dividend out and the quotient in
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_quo <= w_sum_nx;
            r_rem <= '0;
        end else if (i_ctrl.step) begin
            r_quo <= w_quo_nx;
            r_rem <= w_rem_nx;
        end
    end

    // Replace the bias once the last quotient bit is known
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
        end else if (i_ctrl.step && i_ctrl.last) begin
            r_bias <= w_quo_nx[SAMPLE_BITS-1:0];
        end
    end

    assign o_bias = r_bias;

endmodule

// File: rtl/ftbc_row_lane.sv
// One matrix row: coefficient store, multiply-accumulate, shift and saturate.
module ftbc_row_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ftbc_pkg::t_coef_wr                   i_wr,
    input  logic signed [ftbc_pkg::COEF_BITS-1:0] i_coef,
    input  ftbc_pkg::t_row_ctrl                  i_ctrl,
    input  logic signed [SAMPLE_BITS:0]          i_diff,
    input  logic [ftbc_pkg::SHIFT_W-1:0]         i_shift,
    output logic signed [ftbc_pkg::OUT_W-1:0]    o_y
);
    import ftbc_pkg::*;

    localparam int PROD_W = COEF_BITS + SAMPLE_BITS + 1;
    localparam int ACC_W  = PROD_W + 3;

    logic signed [COEF_BITS-1:0] r_coef [CHANNELS];
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [OUT_W-1:0]     r_y;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_sh;
    logic                     w_fits;
    logic signed [OUT_W-1:0]  w_sat;

    // Store this row's coefficients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_coef[c] <= '0;
            end
        end else if (i_wr.en) begin
            r_coef[i_wr.col] <= i_coef;
        end
    end

    // Multiply one column per cycle, accumulate each registered product in the next cycle
    assign w_prod = r_coef[i_ctrl.col] * i_diff;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc) begin
            r_acc <= r_acc + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // Arithmetic shift, then clamp to the signed 32-bit range
    assign w_sh   = r_acc >>> i_shift;
    assign w_fits = (&w_sh[ACC_W-1:OUT_W-1]) | ~(|w_sh[ACC_W-1:OUT_W-1]);
    assign w_sat  = w_fits ? w_sh[OUT_W-1:0]
                  : (w_sh[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fin) begin
            r_y <= w_sat;
        end
    end

    assign o_y = r_y;

endmodule

// File: rtl/force_torque_bias_calibrate_top.sv
// Six-axis force/torque calibration: bias averaging and 6x6 matrix top level.
//
// Input beats on i_in carry a command. A coefficient write (command 0) and a
// bias sample (command 1) produce no output beat. The bias sample that
// completes a run starts the six bias dividers, which run one quotient bit a
// cycle while i_in.ready stays low. Command 3 is dropped.
// A measure beat (command 2) runs through six row lanes in parallel, one
// matrix column per cycle on each lane's multiplier, then through the product
// and accumulator registers and shift/saturate into the output register; a
// new beat is taken only after that result has been loaded.
// The output register decouples o_out from the lanes: a new item may be
// accepted while the last result waits; if the receiver still stalls when the
// next result is done, the block holds it in the lanes and keeps ready low.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 bias
// sample count, 1 output shift); write only while the block is idle.
// Synchronous reset clears coefficients, bias, bias accumulators and the bias flag,
// and sets the bias count to 1 and the output shift to 16.
module force_torque_bias_calibrate_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ftbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ftbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ftbc_in_if.sink                           i_in,
    ftbc_out_if.source                        o_out
);
    import ftbc_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + COUNT_W;
    localparam int CNT_W = $clog2(SUM_W);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [COUNT_W-1:0]         r_count;
    logic [SHIFT_W-1:0]         r_shift;
    logic [COUNT_W-1:0]         r_seen;
    logic                       r_done;
    logic [DIV_W-1:0]           r_div;
    logic signed [SAMPLE_BITS:0] r_diff [CHANNELS];
    logic signed [OUT_W-1:0]    r_res [CHANNELS];
    logic                       r_out_valid;
    logic                       r_out_bias;

    logic [SAMPLE_BITS-1:0]     w_samp [CHANNELS];
    logic [SAMPLE_BITS-1:0]     w_bias [CHANNELS];
    logic signed [OUT_W-1:0]    w_y [CHANNELS];
    logic                       w_accept;
    t_cmd                       w_cmd;
    logic [COUNT_W-1:0]         w_seen_nx;
    logic [COUNT_W-1:0]         w_target;
    logic                       w_finish;
    logic [DIV_W-1:0]           w_div_nx;
    logic [LANE_W-1:0]          w_row;
    logic [LANE_W-1:0]          w_col;
    logic                       w_wr_ok;
    t_coef_wr                   w_wr [CHANNELS];
    t_row_ctrl                  w_row_ctrl;
    t_bias_ctrl                 w_bias_ctrl;
    logic                       w_load;

    assign w_samp[0] = i_in.sample_ch0;
    assign w_samp[1] = i_in.sample_ch1;
    assign w_samp[2] = i_in.sample_ch2;
    assign w_samp[3] = i_in.sample_ch3;
    assign w_samp[4] = i_in.sample_ch4;
    assign w_samp[5] = i_in.sample_ch5;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid & i_in.ready;
    assign w_cmd      = t_cmd'(i_in.command);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(1);
            r_shift <= SHIFT_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIAS_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                CFG_OUT_SHIFT:  r_shift <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Bias run bookkeeping: a zero count acts as one, a wrapped count divides by 1024
    assign w_seen_nx = r_seen + COUNT_W'(1);
    assign w_target  = (r_count == '0) ? COUNT_W'(1) : r_count;
    assign w_finish  = (w_seen_nx >= w_target) || (w_seen_nx == '0);
    assign w_div_nx  = (w_seen_nx == '0) ? {1'b1, {COUNT_W{1'b0}}} : {1'b0, w_seen_nx};

    // Coefficient slot decode
    assign w_row   = coef_row(i_in.coef_index);
    assign w_col   = coef_col(i_in.coef_index);
    assign w_wr_ok = w_accept && (w_cmd == CMD_COEF) && (i_in.coef_index < CIDX_W'(NUM_COEFS));

    always_comb begin
        for (int r = 0; r < CHANNELS; r++) begin
            w_wr[r].en  = w_wr_ok && (w_row == LANE_W'(r));
            w_wr[r].col = w_col;
        end
    end

    // Lane sequencing
    always_comb begin
        w_bias_ctrl.acc   = w_accept && (w_cmd == CMD_BIAS);
        w_bias_ctrl.start = w_bias_ctrl.acc && w_finish;
        w_bias_ctrl.step  = (r_state == S_DIV);
        w_bias_ctrl.last  = (r_cnt == CNT_W'(SUM_W - 1));

        w_row_ctrl.clr = w_accept && (w_cmd == CMD_MEASURE);
        w_row_ctrl.mul = (r_state == S_MAC) && (r_cnt < CNT_W'(CHANNELS));
        w_row_ctrl.acc = (r_state == S_MAC) && (r_cnt >= CNT_W'(1))
                         && (r_cnt <= CNT_W'(CHANNELS));
        w_row_ctrl.fin = (r_state == S_MAC) && (r_cnt == CNT_W'(CHANNELS + 1));
        w_row_ctrl.col = w_row_ctrl.mul ? r_cnt[LANE_W-1:0] : '0;
    end

    assign w_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // Next state and step counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    case (w_cmd)
                        CMD_MEASURE: n_state = S_MAC;
                        CMD_BIAS:    n_state = w_finish ? S_DIV : S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_MAC: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (w_row_ctrl.fin) begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (w_bias_ctrl.last) begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Bias run counter, divisor and completion flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_done <= 1'b0;
        end else begin
            if (w_bias_ctrl.acc) begin
                r_seen <= w_finish ? '0 : w_seen_nx;
            end
            if (w_bias_ctrl.step && w_bias_ctrl.last) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bias_ctrl.start) begin
            r_div <= w_div_nx;
        end
    end

    // Capture bias-corrected codes of a measure beat
    always_ff @(posedge i_clk) begin
        if (w_row_ctrl.clr) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_diff[c] <= $signed({1'b0, w_samp[c]}) - $signed({1'b0, w_bias[c]});
            end
        end
    end

    // Lanes
    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        ftbc_bias_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_bias (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_bias_ctrl),
            .i_sample (w_samp[g]),
            .i_div    (r_div),
            .o_bias   (w_bias[g])
        );

        ftbc_row_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr[g]),
            .i_coef  (i_in.coef_value),
            .i_ctrl  (w_row_ctrl),
            .i_diff  (r_diff[w_row_ctrl.col]),
            .i_shift (r_shift),
            .o_y     (w_y[g])
        );
    end

    // Merge lane results into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int r = 0; r < CHANNELS; r++) begin
                r_res[r] <= w_y[r];
            end
            r_out_bias <= r_done;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.force_x    = r_res[0];
    assign o_out.force_y    = r_res[1];
    assign o_out.force_z    = r_res[2];
    assign o_out.torque_x   = r_res[3];
    assign o_out.torque_y   = r_res[4];
    assign o_out.torque_z   = r_res[5];
    assign o_out.bias_valid = r_out_bias;

endmodule
